// File: src/sv32_tlb_pkg.sv
// shared types and constants for the sv32 direct-mapped tlb
// request and result payloads, stored entry layouts, array commands
// no dependencies
package sv32_tlb_pkg;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned PG_SHIFT    = 12;
    localparam int unsigned VPN_W       = ADDR_W - PG_SHIFT;
    localparam int unsigned FRAME_W     = 22;
    localparam int unsigned PERM_W      = 4;
    // a superpage keeps 22 offset bits
    localparam int unsigned SUPER_OFF_W = PG_SHIFT + 10;
    // ppn of a pte starts here
    localparam int unsigned PTE_PPN_LSB = PG_SHIFT - 2;
    localparam int unsigned PTE_D_BIT   = 7;

    // permission bit positions inside a stored entry
    localparam int unsigned PERM_R_BIT = 0;
    localparam int unsigned PERM_W_BIT = 1;
    localparam int unsigned PERM_X_BIT = 2;

    typedef enum logic [1:0] {
        REQ_LOOKUP    = 2'd0,
        REQ_FILL      = 2'd1,
        REQ_FLUSH     = 2'd2,
        REQ_FLUSH_ALL = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t           req_type;
        logic                tlb_select;
        logic                access_write;
        logic [ADDR_W-1:0]   virt_addr;
        logic [ADDR_W-1:0]   pte_word;
        logic [ADDR_W-1:0]   pte_location;
        logic                super_page;
    } tlb_req_t;

    typedef struct packed {
        logic                hit;
        logic [ADDR_W-1:0]   phys_addr;
        logic                set_dirty;
        logic [ADDR_W-1:0]   dirty_pte_location;
    } tlb_rsp_t;

    // data tlb entry
    typedef struct packed {
        logic [VPN_W-1:0]    tag;
        logic [FRAME_W-1:0]  frame;
        logic [ADDR_W-1:0]   pte_loc;
        logic [PERM_W-1:0]   perm;
        logic                dirty;
        logic                super_pg;
    } dat_entry_t;

    // instruction tlb entry
    typedef struct packed {
        logic [VPN_W-1:0]    tag;
        logic [FRAME_W-1:0]  frame;
        logic [PERM_W-1:0]   perm;
        logic                super_pg;
    } ins_entry_t;

    // update of one entry array
    typedef struct packed {
        logic write;
        logic clear;
        logic clear_all;
    } arr_cmd_t;

    // physical address from a stored frame
    function automatic logic [ADDR_W-1:0] make_phys(
        input logic [FRAME_W-1:0] frame,
        input logic               super_pg,
        input logic [ADDR_W-1:0]  va
    );
        logic [ADDR_W-1:0] pa;
        if (super_pg) begin
            // frame bits above the 32-bit space drop out
            pa = {frame[PTE_PPN_LSB + ADDR_W - SUPER_OFF_W - 1:PTE_PPN_LSB],
                  va[SUPER_OFF_W-1:0]};
        end else begin
            pa = {frame[VPN_W-1:0], va[PG_SHIFT-1:0]};
        end
        return pa;
    endfunction

endpackage

// File: src/sv32_tlb_index.sv
// set index from the virtual page number: page number modulo entry count
// reciprocal multiply in the first stage, product fold and correction after it
// depends on sv32_tlb_pkg
module sv32_tlb_index #(
    parameter int unsigned TLB_ENTRIES = 64
) (
    input  logic                                 aclk,
    input  logic                                 load,
    input  logic [sv32_tlb_pkg::VPN_W-1:0]       vpn,
    output logic [$clog2(TLB_ENTRIES)-1:0]       index
);
    import sv32_tlb_pkg::*;

    localparam int unsigned IDX_W = $clog2(TLB_ENTRIES);
    localparam int unsigned R_W   = IDX_W + 1;
    localparam int unsigned P_W   = 2 * VPN_W;
    // floor(2^20 / entries), quotient estimate is low by at most one
    localparam int unsigned RECIP = (32'd1 << VPN_W) / TLB_ENTRIES;
    localparam logic [P_W-1:0] RECIP_C = P_W'(RECIP);
    localparam logic [R_W-1:0] ENT_C   = R_W'(TLB_ENTRIES);

    logic [P_W-1:0]   prod;
    logic [VPN_W-1:0] quot_reg;
    logic [R_W-1:0]   vpn_lo_reg;
    logic [R_W-1:0]   qn_lo;
    logic [R_W-1:0]   rem;
    logic [R_W-1:0]   rem_fix;

    // quotient estimate
    assign prod = P_W'(vpn) * RECIP_C;

    always_ff @(posedge aclk) begin
        if (load) begin
            quot_reg   <= prod[P_W-1:VPN_W];
            vpn_lo_reg <= vpn[R_W-1:0];
        end
    end

    // remainder lies below twice the entry count, so low bits suffice
    assign qn_lo   = quot_reg[R_W-1:0] * ENT_C;
    assign rem     = vpn_lo_reg - qn_lo;
    assign rem_fix = (rem >= ENT_C) ? (rem - ENT_C) : rem;
    assign index   = rem_fix[IDX_W-1:0];

endmodule

// File: src/sv32_tlb_array.sv
// one tlb entry store: entry memory with registered read and write bypass,
// valid bits in flip-flops with single clear and clear-all
// depends on sv32_tlb_pkg
module sv32_tlb_array #(
    parameter int unsigned ENTRIES = 64,
    parameter int unsigned WORD_W  = 80
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [$clog2(ENTRIES)-1:0]   rd_idx,
    output logic [WORD_W-1:0]            rd_word,
    input  logic [$clog2(ENTRIES)-1:0]   vld_idx,
    output logic                         vld,
    input  sv32_tlb_pkg::arr_cmd_t       cmd,
    input  logic [$clog2(ENTRIES)-1:0]   wr_idx,
    input  logic [WORD_W-1:0]            wr_word
);
    import sv32_tlb_pkg::*;

    logic [WORD_W-1:0]  mem [ENTRIES];
    logic [WORD_W-1:0]  rd_word_reg;
    logic [ENTRIES-1:0] vld_reg;
    logic [ENTRIES-1:0] vld_next;

    // entry write
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            mem[wr_idx] <= wr_word;
        end
    end

    // registered read, newest data when the same entry is written this cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (cmd.write && (wr_idx == rd_idx)) begin
                rd_word_reg <= wr_word;
            end else begin
                rd_word_reg <= mem[rd_idx];
            end
        end
    end

    assign rd_word = rd_word_reg;

    // valid bits
    always_comb begin
        vld_next = vld_reg;
        if (cmd.clear_all) begin
            vld_next = '0;
        end else if (cmd.write) begin
            vld_next[wr_idx] = 1'b1;
        end else if (cmd.clear) begin
            vld_next[wr_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign vld = vld_reg[vld_idx];

endmodule

// File: src/sv32_tlb_resolve.sv
// request decode against both entries read at the set index:
// hit and permission check, dirty update, fill and flush commands
// depends on sv32_tlb_pkg
module sv32_tlb_resolve (
    input  sv32_tlb_pkg::tlb_req_t    req,
    input  sv32_tlb_pkg::dat_entry_t  dat_ent,
    input  logic                      dat_vld,
    input  sv32_tlb_pkg::ins_entry_t  ins_ent,
    input  logic                      ins_vld,
    output sv32_tlb_pkg::tlb_rsp_t    rsp,
    output sv32_tlb_pkg::arr_cmd_t    dat_cmd,
    output sv32_tlb_pkg::dat_entry_t  dat_wr,
    output sv32_tlb_pkg::arr_cmd_t    ins_cmd,
    output sv32_tlb_pkg::ins_entry_t  ins_wr
);
    import sv32_tlb_pkg::*;

    logic [VPN_W-1:0] vpn;
    logic             dat_tag_hit;
    logic             ins_tag_hit;
    logic             dat_perm_ok;

    assign vpn         = req.virt_addr[ADDR_W-1:PG_SHIFT];
    assign dat_tag_hit = dat_vld && (dat_ent.tag == vpn);
    assign ins_tag_hit = ins_vld && (ins_ent.tag == vpn);
    assign dat_perm_ok = req.access_write ? dat_ent.perm[PERM_W_BIT]
                                          : dat_ent.perm[PERM_R_BIT];

    always_comb begin
        rsp     = '0;
        dat_cmd = '0;
        ins_cmd = '0;
        dat_wr  = dat_ent;
        ins_wr  = ins_ent;
        case (req.req_type)
            REQ_LOOKUP: begin
                if (req.tlb_select) begin
                    if (ins_tag_hit && ins_ent.perm[PERM_X_BIT]) begin
                        rsp.hit       = 1'b1;
                        rsp.phys_addr = make_phys(ins_ent.frame, ins_ent.super_pg,
                                                  req.virt_addr);
                    end
                end else if (dat_tag_hit && dat_perm_ok) begin
                    rsp.hit       = 1'b1;
                    rsp.phys_addr = make_phys(dat_ent.frame, dat_ent.super_pg,
                                              req.virt_addr);
                    // first write to a clean page
                    if (req.access_write && !dat_ent.dirty) begin
                        rsp.set_dirty          = 1'b1;
                        rsp.dirty_pte_location = dat_ent.pte_loc;
                        dat_cmd.write          = 1'b1;
                        dat_wr.dirty           = 1'b1;
                    end
                end
            end
            REQ_FILL: begin
                if (req.tlb_select) begin
                    ins_cmd.write   = 1'b1;
                    ins_wr.tag      = vpn;
                    ins_wr.frame    = req.pte_word[ADDR_W-1:PTE_PPN_LSB];
                    ins_wr.perm     = req.pte_word[PERM_W:1];
                    ins_wr.super_pg = req.super_page;
                end else begin
                    dat_cmd.write   = 1'b1;
                    dat_wr.tag      = vpn;
                    dat_wr.frame    = req.pte_word[ADDR_W-1:PTE_PPN_LSB];
                    dat_wr.pte_loc  = req.pte_location;
                    dat_wr.perm     = req.pte_word[PERM_W:1];
                    dat_wr.dirty    = req.pte_word[PTE_D_BIT];
                    dat_wr.super_pg = req.super_page;
                end
            end
            REQ_FLUSH: begin
                dat_cmd.clear = dat_tag_hit;
                ins_cmd.clear = ins_tag_hit;
            end
            REQ_FLUSH_ALL: begin
                dat_cmd.clear_all = 1'b1;
                ins_cmd.clear_all = 1'b1;
            end
            default: begin
                rsp = '0;
            end
        endcase
    end

endmodule

// File: src/sv32_direct_mapped_tlb.sv
// Sv32 direct-mapped data and instruction tlbs.
// Input channel s_valid/s_ready/s_data carries one request: lookup, fill,
// flush of one page, or flush of everything. Result channel
// m_valid/m_ready/m_data returns exactly one result per request, in order.
// A data write hitting a clean entry raises set_dirty with the stored pte
// location and marks the entry dirty.
// Throughput: one request per cycle while the result side does not stall. A
// request passes the first stage (reciprocal multiply into a register, then
// fold), the second stage (registered entry read), then the result
// register.
// Each tlb holds TLB_ENTRIES entries indexed by page number modulo
// TLB_ENTRIES; the set index is computed in the first stage.
// Reset clears all valid bits, pipeline and result valids; the block takes
// requests as soon as reset is released.
// When m_ready is low the result is held and the pipeline fills; s_ready
// drops only once both internal stages and the result register are full.
// depends on sv32_tlb_pkg, sv32_tlb_index, sv32_tlb_array, sv32_tlb_resolve
module sv32_direct_mapped_tlb #(
    parameter int unsigned TLB_ENTRIES = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  sv32_tlb_pkg::tlb_req_t  s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output sv32_tlb_pkg::tlb_rsp_t  m_data
);
    import sv32_tlb_pkg::*;

    localparam int unsigned IDX_W = $clog2(TLB_ENTRIES);

    logic             s1_valid_reg;
    tlb_req_t         s1_req_reg;
    logic [IDX_W-1:0] s1_idx;
    logic             s2_valid_reg;
    tlb_req_t         s2_req_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic             m_valid_reg;
    tlb_rsp_t         m_data_reg;

    logic             out_free;
    logic             s2_free;
    logic             s2_fire;

    dat_entry_t       dat_rd;
    dat_entry_t       dat_wr;
    logic             dat_vld;
    arr_cmd_t         dat_cmd;
    arr_cmd_t         dat_cmd_gated;
    ins_entry_t       ins_rd;
    ins_entry_t       ins_wr;
    logic             ins_vld;
    arr_cmd_t         ins_cmd;
    arr_cmd_t         ins_cmd_gated;
    tlb_rsp_t         rsp;

    // pipeline flow
    assign out_free = !m_valid_reg || m_ready;
    assign s2_fire  = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s_ready  = !s1_valid_reg || s2_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_valid_reg && s_ready ? s1_valid_reg : 1'b0;
            end
            if (out_free) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            s1_req_reg <= s_data;
        end
        if (s2_free) begin
            s2_req_reg <= s1_req_reg;
            s2_idx_reg <= s1_idx;
        end
        if (s2_fire) begin
            m_data_reg <= rsp;
        end
    end

    // set index
    sv32_tlb_index #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_index (
        .aclk  (aclk),
        .load  (s_ready),
        .vpn   (s_data.virt_addr[ADDR_W-1:PG_SHIFT]),
        .index (s1_idx)
    );

    // updates only from a request leaving the last stage
    assign dat_cmd_gated = s2_fire ? dat_cmd : '0;
    assign ins_cmd_gated = s2_fire ? ins_cmd : '0;

    // data tlb
    sv32_tlb_array #(
        .ENTRIES (TLB_ENTRIES),
        .WORD_W  ($bits(dat_entry_t))
    ) u_dat (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s2_free),
        .rd_idx  (s1_idx),
        .rd_word (dat_rd),
        .vld_idx (s2_idx_reg),
        .vld     (dat_vld),
        .cmd     (dat_cmd_gated),
        .wr_idx  (s2_idx_reg),
        .wr_word (dat_wr)
    );

    // instruction tlb
    sv32_tlb_array #(
        .ENTRIES (TLB_ENTRIES),
        .WORD_W  ($bits(ins_entry_t))
    ) u_ins (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s2_free),
        .rd_idx  (s1_idx),
        .rd_word (ins_rd),
        .vld_idx (s2_idx_reg),
        .vld     (ins_vld),
        .cmd     (ins_cmd_gated),
        .wr_idx  (s2_idx_reg),
        .wr_word (ins_wr)
    );

    // hit check and entry updates
    sv32_tlb_resolve u_resolve (
        .req     (s2_req_reg),
        .dat_ent (dat_rd),
        .dat_vld (dat_vld),
        .ins_ent (ins_rd),
        .ins_vld (ins_vld),
        .rsp     (rsp),
        .dat_cmd (dat_cmd),
        .dat_wr  (dat_wr),
        .ins_cmd (ins_cmd),
        .ins_wr  (ins_wr)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: dv/sv32_direct_mapped_tlb_test.sv
// self-checking testbench for the sv32 direct-mapped data and instruction tlbs
// keeps its own copy of both tlbs and checks every result in order
// depends on sv32_tlb_pkg and sv32_direct_mapped_tlb
module sv32_direct_mapped_tlb_test;
    import sv32_tlb_pkg::*;

    localparam int unsigned SLOTS     = 64;
    localparam int unsigned RUN_LIMIT = 4_000_000;
    localparam int unsigned DRAIN_CYC = 10;

    // permission masks as stored in an entry (u, x, w, r)
    localparam logic [3:0] PERM_RD = 4'b0001;
    localparam logic [3:0] PERM_WR = 4'b0010;
    localparam logic [3:0] PERM_EX = 4'b0100;
    localparam logic [3:0] PERM_US = 4'b1000;

    // pages for the directed checks; page c and page e share a slot
    localparam logic [19:0] PAGE_A = 20'h12345;
    localparam logic [19:0] PAGE_B = 20'h00A01;
    localparam logic [19:0] PAGE_C = 20'h70042;
    localparam logic [19:0] PAGE_D = 20'h55503;
    localparam logic [19:0] PAGE_E = 20'h80042;
    localparam logic [19:0] PAGE_TOP = 20'hFFFFF;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    tlb_req_t s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    tlb_rsp_t m_data;

    // shadow copy of both tlbs
    logic              dat_valid [SLOTS];
    logic [VPN_W-1:0]  dat_tag   [SLOTS];
    logic [FRAME_W-1:0] dat_frame [SLOTS];
    logic [ADDR_W-1:0] dat_loc   [SLOTS];
    logic [3:0]        dat_perm  [SLOTS];
    logic              dat_dirty [SLOTS];
    logic              dat_super [SLOTS];
    logic              ins_valid [SLOTS];
    logic [VPN_W-1:0]  ins_tag   [SLOTS];
    logic [FRAME_W-1:0] ins_frame [SLOTS];
    logic [3:0]        ins_perm  [SLOTS];
    logic              ins_super [SLOTS];

    tlb_rsp_t    pending_rsp [$];
    int unsigned mismatch_count = 0;
    int unsigned stall_left     = 0;
    bit          idle_on        = 1'b1;

    sv32_direct_mapped_tlb #(
        .TLB_ENTRIES(SLOTS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // physical address from a stored frame
    function automatic logic [ADDR_W-1:0] frame_to_phys(
        input logic [FRAME_W-1:0] frame,
        input logic               sup,
        input logic [ADDR_W-1:0]  va
    );
        if (sup) begin
            return {frame[19:10], va[21:0]};
        end
        return {frame[19:0], va[11:0]};
    endfunction

    // expected result of one request, updating the shadow tlbs
    function automatic tlb_rsp_t translate_request(input tlb_req_t r);
        logic [VPN_W-1:0]  vpn;
        int unsigned       slot;
        logic              allowed;
        tlb_rsp_t          rsp;
        vpn  = r.virt_addr[31:12];
        slot = vpn % SLOTS;
        rsp  = '0;
        case (r.req_type)
            REQ_LOOKUP: begin
                if (r.tlb_select) begin
                    if (ins_valid[slot] && ins_tag[slot] == vpn
                            && ins_perm[slot][PERM_X_BIT]) begin
                        rsp.hit       = 1'b1;
                        rsp.phys_addr = frame_to_phys(ins_frame[slot], ins_super[slot],
                                                      r.virt_addr);
                    end
                end else begin
                    allowed = r.access_write ? dat_perm[slot][PERM_W_BIT]
                                             : dat_perm[slot][PERM_R_BIT];
                    if (dat_valid[slot] && dat_tag[slot] == vpn && allowed) begin
                        // first write to a clean page asks for the d bit
                        if (r.access_write && !dat_dirty[slot]) begin
                            rsp.set_dirty          = 1'b1;
                            rsp.dirty_pte_location = dat_loc[slot];
                            dat_dirty[slot]        = 1'b1;
                        end
                        rsp.hit       = 1'b1;
                        rsp.phys_addr = frame_to_phys(dat_frame[slot], dat_super[slot],
                                                      r.virt_addr);
                    end
                end
            end
            REQ_FILL: begin
                if (r.tlb_select) begin
                    ins_tag[slot]   = vpn;
                    ins_frame[slot] = r.pte_word[31:10];
                    ins_perm[slot]  = r.pte_word[4:1];
                    ins_super[slot] = r.super_page;
                    ins_valid[slot] = 1'b1;
                end else begin
                    dat_tag[slot]   = vpn;
                    dat_frame[slot] = r.pte_word[31:10];
                    dat_loc[slot]   = r.pte_location;
                    dat_perm[slot]  = r.pte_word[4:1];
                    dat_dirty[slot] = r.pte_word[PTE_D_BIT];
                    dat_super[slot] = r.super_page;
                    dat_valid[slot] = 1'b1;
                end
            end
            REQ_FLUSH: begin
                if (dat_valid[slot] && dat_tag[slot] == vpn) begin
                    dat_valid[slot] = 1'b0;
                end
                if (ins_valid[slot] && ins_tag[slot] == vpn) begin
                    ins_valid[slot] = 1'b0;
                end
            end
            default: begin
                for (int k = 0; k < SLOTS; k++) begin
                    dat_valid[k] = 1'b0;
                    ins_valid[k] = 1'b0;
                end
            end
        endcase
        return rsp;
    endfunction

    function automatic logic [31:0] leaf_pte(
        input logic [21:0] ppn,
        input logic        dbit,
        input logic [3:0]  perm
    );
        return {ppn, 2'b00, dbit, 2'b00, perm, 1'b1};
    endfunction

    function automatic void check_field(
        input string       field,
        input logic [31:0] want,
        input logic [31:0] got
    );
        if (want !== got) begin
            $error("%s: expected %h, got %h", field, want, got);
            mismatch_count++;
        end
    endfunction

    // result side: random stall bursts while idling is on
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 17);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        tlb_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("result with no request outstanding");
                mismatch_count++;
            end else begin
                want = pending_rsp.pop_front();
                check_field("hit", 32'(want.hit), 32'(m_data.hit));
                check_field("phys_addr", want.phys_addr, m_data.phys_addr);
                check_field("set_dirty", 32'(want.set_dirty), 32'(m_data.set_dirty));
                check_field("dirty_pte_location", want.dirty_pte_location,
                            m_data.dirty_pte_location);
            end
        end
    end

    // present one request, wait for the handshake, record its expected result
    task automatic send_request(input tlb_req_t r);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        pending_rsp.push_back(translate_request(r));
    endtask

    task automatic lookup(input logic sel, input logic wr, input logic [31:0] va);
        tlb_req_t r;
        r              = '0;
        r.req_type     = REQ_LOOKUP;
        r.tlb_select   = sel;
        r.access_write = wr;
        r.virt_addr    = va;
        send_request(r);
    endtask

    task automatic fill(
        input logic        sel,
        input logic [31:0] va,
        input logic [31:0] pte,
        input logic [31:0] loc,
        input logic        sup
    );
        tlb_req_t r;
        r              = '0;
        r.req_type     = REQ_FILL;
        r.tlb_select   = sel;
        r.virt_addr    = va;
        r.pte_word     = pte;
        r.pte_location = loc;
        r.super_page   = sup;
        send_request(r);
    endtask

    task automatic flush_page(input logic sel, input logic [31:0] va);
        tlb_req_t r;
        r            = '0;
        r.req_type   = REQ_FLUSH;
        r.tlb_select = sel;
        r.virt_addr  = va;
        send_request(r);
    endtask

    task automatic flush_all();
        tlb_req_t r;
        r          = '0;
        r.req_type = REQ_FLUSH_ALL;
        send_request(r);
    endtask

    // hold the request side until every result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
    endtask

    // write every slot of both tlbs once so later reads never see unwritten entries
    task automatic fill_every_slot();
        logic [19:0] vpn;
        for (int s = 0; s < SLOTS; s++) begin
            for (int sel = 0; sel < 2; sel++) begin
                vpn = {14'($urandom), 6'(s)};
                fill(sel[0], {vpn, 12'($urandom)}, $urandom, $urandom, 1'($urandom));
            end
        end
        flush_all();
    endtask

    // read and write permission, dirty request on first write only
    task automatic test_data_permissions();
        fill(1'b0, {PAGE_A, 12'h000}, leaf_pte(22'h3FFFFF, 1'b0, PERM_RD | PERM_WR),
             32'hDEADBEEC, 1'b0);
        lookup(1'b0, 1'b0, {PAGE_A, 12'hFFF});
        lookup(1'b0, 1'b1, {PAGE_A, 12'h800});
        lookup(1'b0, 1'b1, {PAGE_A, 12'h001});
        fill(1'b0, {PAGE_B, 12'h123}, leaf_pte(22'h000001, 1'b0, PERM_RD), 32'hFFFFFFFF, 1'b0);
        lookup(1'b0, 1'b1, {PAGE_B, 12'h000});
        lookup(1'b0, 1'b0, {PAGE_B, 12'h000});
        fill(1'b0, {PAGE_C, 12'h000}, leaf_pte(22'h0ABCDE, 1'b1, PERM_WR | PERM_US),
             32'h00000004, 1'b0);
        lookup(1'b0, 1'b1, {PAGE_C, 12'h7FF});
    endtask

    // fetches need execute and ignore the write flag
    task automatic test_fetch();
        fill(1'b1, {PAGE_A, 12'h000}, leaf_pte(22'h000000, 1'b0, PERM_EX | PERM_US),
             32'h0, 1'b0);
        lookup(1'b1, 1'b1, {PAGE_A, 12'h004});
        lookup(1'b1, 1'b0, {PAGE_B, 12'h000});
        fill(1'b1, {PAGE_D, 12'h000}, leaf_pte(22'h155555, 1'b1, PERM_RD | PERM_WR),
             32'h0, 1'b0);
        lookup(1'b1, 1'b0, {PAGE_D, 12'h010});
    endtask

    // superpages keep 22 offset bits, misaligned frame bits are dropped
    task automatic test_superpage();
        fill(1'b0, {PAGE_TOP, 12'h000}, leaf_pte(22'h2AA5A5, 1'b0, PERM_RD), 32'h10, 1'b1);
        lookup(1'b0, 1'b0, 32'hFFFFFFFF);
        fill(1'b1, 32'h00000000, leaf_pte(22'h3FFFFF, 1'b0, PERM_EX), 32'h0, 1'b1);
        lookup(1'b1, 1'b0, 32'h00000000);
    endtask

    // single flush hits both tlbs on a tag match only, flush-all clears everything
    task automatic test_flush();
        flush_page(1'b1, {PAGE_A, 12'hABC});
        lookup(1'b0, 1'b0, {PAGE_A, 12'h000});
        lookup(1'b1, 1'b0, {PAGE_A, 12'h000});
        fill(1'b0, {PAGE_E, 12'h000}, leaf_pte(22'h001234, 1'b0, PERM_RD), 32'h20, 1'b0);
        lookup(1'b0, 1'b1, {PAGE_C, 12'h000});
        flush_page(1'b0, {PAGE_C, 12'h000});
        lookup(1'b0, 1'b0, {PAGE_E, 12'h444});
        flush_all();
        lookup(1'b0, 1'b0, {PAGE_E, 12'h444});
    endtask

    // mostly fills and lookups on a small pool of pages, some of them colliding,
    // with flushes and fully random requests mixed in
    task automatic random_traffic(input int unsigned count, input bit with_idle);
        logic [19:0] pool [16];
        logic [31:0] va;
        tlb_req_t    r;
        int unsigned roll;
        idle_on = with_idle;
        for (int k = 0; k < 8; k++) begin
            pool[k] = 20'($urandom);
        end
        for (int k = 8; k < 16; k++) begin
            pool[k] = {pool[k-8][19:6] ^ 14'($urandom_range(1, 16383)), pool[k-8][5:0]};
        end
        repeat (count) begin
            roll = $urandom_range(0, 99);
            va   = {pool[$urandom_range(0, 15)], 12'($urandom)};
            if (roll < 25) begin
                fill(1'($urandom), va, $urandom, $urandom, $urandom_range(0, 3) == 0);
            end else if (roll < 75) begin
                lookup(1'($urandom), 1'($urandom), va);
            end else if (roll < 85) begin
                flush_page(1'($urandom), va);
            end else if (roll < 87) begin
                flush_all();
            end else begin
                r.req_type     = req_type_t'($urandom_range(0, 3));
                r.tlb_select   = 1'($urandom);
                r.access_write = 1'($urandom);
                r.virt_addr    = $urandom;
                r.pte_word     = $urandom;
                r.pte_location = $urandom;
                r.super_page   = 1'($urandom);
                send_request(r);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        fill_every_slot();
        test_data_permissions();
        test_fetch();
        test_superpage();
        test_flush();
        wait_drained();
        random_traffic(190, 1'b1);
        wait_drained();
        random_traffic(90, 1'b0);
        random_traffic(150, 1'b1);
        random_traffic(64, 1'b0);
        wait_drained();
        repeat (DRAIN_CYC) @(posedge aclk);
        if (mismatch_count == 0 && pending_rsp.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/sv32_tlb_pkg.sv
src/sv32_tlb_index.sv
src/sv32_tlb_array.sv
src/sv32_tlb_resolve.sv
src/sv32_direct_mapped_tlb.sv
dv/sv32_direct_mapped_tlb_test.sv
